### rtl/core/ssb_pkg.sv
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types, constants and command tables for the SD SPI boot sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssb_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_SECTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUMMY_BYTES = 2'd3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register reset values
    localparam logic [31:0] BOOT_SECTOR_RST = 32'd128;
    localparam logic [15:0] LOAD_BASE_RST   = 16'h1000;
    localparam logic [7:0]  POLL_LIMIT_RST  = 8'd10;
    localparam logic [7:0]  DUMMY_BYTES_RST = 8'd10;

    localparam int unsigned BLOCK_BYTES_DEF = 512;
    localparam int unsigned DATA_CNT_W      = 10;

    // Input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_XFER  = 1'b1;

    // Byte values
    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] TOKEN_DATA = 8'hFE;
    localparam logic [7:0] CMD_START  = 8'h40;

    // Command slots, in sequence order
    localparam logic [2:0] CMD_GO_IDLE   = 3'd0;  // CMD0
    localparam logic [2:0] CMD_IF_COND   = 3'd1;  // CMD8
    localparam logic [2:0] CMD_APP       = 3'd2;  // CMD55
    localparam logic [2:0] CMD_SEND_OP   = 3'd3;  // ACMD41
    localparam logic [2:0] CMD_READ_BLK  = 3'd4;  // CMD17

    localparam logic [2:0] CMD_IDX_CRC   = 3'd6;  // last byte of a command frame
    localparam logic [2:0] R7_LAST       = 3'd4;
    localparam logic [2:0] CRC_LAST      = 3'd2;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_DUMMY = 9'b000000010,
        PH_SEND  = 9'b000000100,
        PH_POLL  = 9'b000001000,
        PH_R7    = 9'b000010000,
        PH_TOKEN = 9'b000100000,
        PH_DATA  = 9'b001000000,
        PH_CRC   = 9'b010000000,
        PH_DONE  = 9'b100000000
    } t_phase;

    function automatic logic [7:0] cmd_code(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            CMD_GO_IDLE:  c = 8'd0;
            CMD_IF_COND:  c = 8'd8;
            CMD_APP:      c = 8'd55;
            CMD_SEND_OP:  c = 8'd41;
            default:      c = 8'd17;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cmd_crc(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            CMD_GO_IDLE:  c = 8'h95;
            CMD_IF_COND:  c = 8'h87;
            CMD_APP:      c = 8'h65;
            CMD_SEND_OP:  c = 8'h77;
            default:      c = 8'hFF;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] cmd_arg(input logic [2:0] k, input logic [31:0] sector);
        logic [31:0] a;
        case (k)
            CMD_IF_COND:  a = 32'h0000_01AA;
            CMD_SEND_OP:  a = 32'h4000_0000;
            CMD_READ_BLK: a = sector;
            default:      a = 32'h0;
        endcase
        return a;
    endfunction

    // Byte i of the seven-byte frame for command k
    function automatic logic [7:0] cmd_byte(input logic [2:0] k, input logic [2:0] i,
                                            input logic [31:0] sector);
        logic [31:0] a;
        logic [7:0]  b;
        a = cmd_arg(k, sector);
        case (i)
            3'd0:    b = BYTE_IDLE;
            3'd1:    b = cmd_code(k) | CMD_START;
            3'd2:    b = a[31:24];
            3'd3:    b = a[23:16];
            3'd4:    b = a[15:8];
            3'd5:    b = a[7:0];
            default: b = cmd_crc(k);
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ssb_if.sv
// ----------------------------------------------------------------------------
// ssb_if
// Valid/ready channels of the SD SPI boot sequencer: input, result, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssb_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;
    modport source (output valid, op, rx_byte, input ready);
    modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface ssb_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        send;
    logic        cs_high;
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        boot_done;
    modport source (output valid, tx_byte, send, cs_high, write_valid, write_addr,
                    write_data, boot_done, input ready);
    modport sink   (input valid, tx_byte, send, cs_high, write_valid, write_addr,
                    write_data, boot_done, output ready);
endinterface

interface ssb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/sd_spi_boot_sequencer_core.sv
// ----------------------------------------------------------------------------
// sd_spi_boot_sequencer_core
// SD card SPI-mode init and single block read, one decision per SPI beat.
// ----------------------------------------------------------------------------
// The result beat follows in the cycle after its input beat (result register).
// Throughput: 1 beat per cycle unless o_out stalls; state updates in the same
//   cycle an input beat is taken, so the next beat may follow at once.
// Reset (i_rst_n low, synchronous): sequencer idle, counters cleared, result
//   register empty, config registers back to their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_boot_sequencer_core #(
    parameter int unsigned BLOCK_BYTES = ssb_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssb_in_if.sink     i_in,
    ssb_cfg_if.sink    i_cfg,
    ssb_out_if.source  o_out
);
    import ssb_pkg::*;

    // Data counter wraps at 10 bits; a 1024-byte block ends when it wraps to 0
    localparam logic [DATA_CNT_W-1:0] BLK_END = DATA_CNT_W'(BLOCK_BYTES % 1024);

    // Configuration
    logic [31:0] r_boot_sector;
    logic [15:0] r_load_base;
    logic [7:0]  r_poll_limit;
    logic [7:0]  r_dummy_bytes;

    // Sequencer state
    t_phase                r_phase,    n_phase;
    logic [2:0]            r_cmd,      n_cmd;      // current command slot
    logic [2:0]            r_idx,      n_idx;      // byte within frame / R7 / CRC
    logic [7:0]            r_poll_cnt, n_poll_cnt;
    logic [7:0]            r_dummy_cnt, n_dummy_cnt;
    logic [DATA_CNT_W-1:0] r_data_cnt, n_data_cnt;

    // Result register
    logic        r_out_valid;
    logic [7:0]  r_tx,   n_tx;
    logic        r_send, n_send;
    logic        r_cs,   n_cs;
    logic        r_wv,   n_wv;
    logic [15:0] r_wa,   n_wa;
    logic [7:0]  r_wd,   n_wd;
    logic        r_done, n_done;

    logic                  in_beat;
    logic                  running;
    logic                  resp_end;
    logic [DATA_CNT_W-1:0] data_inc;

    // Result register drains or is empty: take the next beat
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_beat    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign running  = (r_phase != PH_IDLE) && (r_phase != PH_DONE);
    // Response seen (bit 7 clear) or poll budget spent
    assign resp_end = !i_in.rx_byte[7] || (r_poll_cnt >= r_poll_limit);
    assign data_inc = r_data_cnt + DATA_CNT_W'(1);

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_poll_cnt  = r_poll_cnt;
        n_dummy_cnt = r_dummy_cnt;
        n_data_cnt  = r_data_cnt;

        n_tx   = BYTE_IDLE;
        n_send = 1'b0;
        n_cs   = 1'b1;
        n_wv   = 1'b0;
        n_wa   = 16'h0;
        n_wd   = 8'h0;
        n_done = 1'b0;

        if (i_in.op == OP_START) begin
            if (running) begin
                // Start mid-run is dropped; report the current CS level
                n_cs = (r_phase == PH_DUMMY);
            end else begin
                n_phase     = PH_DUMMY;
                n_dummy_cnt = 8'd1;
                n_idx       = 3'd0;
                n_poll_cnt  = 8'd0;
                n_data_cnt  = '0;
                n_send      = 1'b1;
            end
        end else if (!running) begin
            n_done = (r_phase == PH_DONE);
        end else begin
            n_send = 1'b1;
            n_cs   = 1'b0;
            case (r_phase)
                PH_DUMMY: begin
                    if (r_dummy_cnt < r_dummy_bytes) begin
                        n_dummy_cnt = r_dummy_cnt + 8'd1;
                        n_cs        = 1'b1;
                    end else begin
                        n_phase = PH_SEND;
                        n_cmd   = CMD_GO_IDLE;
                        n_idx   = 3'd1;
                    end
                end
                PH_SEND: begin
                    if (r_idx <= CMD_IDX_CRC) begin
                        n_tx  = cmd_byte(r_cmd, r_idx, r_boot_sector);
                        n_idx = r_idx + 3'd1;
                    end else begin
                        n_phase    = PH_POLL;
                        n_poll_cnt = 8'd1;
                    end
                end
                PH_POLL: begin
                    if (resp_end) begin
                        case (r_cmd)
                            CMD_GO_IDLE: begin
                                n_phase = PH_SEND;
                                n_cmd   = CMD_IF_COND;
                                n_idx   = 3'd1;
                            end
                            CMD_IF_COND: begin
                                n_phase = PH_R7;
                                n_idx   = 3'd1;
                            end
                            CMD_APP: begin
                                n_phase = PH_SEND;
                                n_cmd   = CMD_SEND_OP;
                                n_idx   = 3'd1;
                            end
                            CMD_SEND_OP: begin
                                // Card ready only on a zero response
                                n_phase = PH_SEND;
                                n_cmd   = (i_in.rx_byte == 8'h00) ? CMD_READ_BLK : CMD_APP;
                                n_idx   = 3'd1;
                            end
                            default: begin
                                n_phase = PH_TOKEN;
                            end
                        endcase
                    end else begin
                        n_poll_cnt = r_poll_cnt + 8'd1;
                    end
                end
                PH_R7: begin
                    if (r_idx < R7_LAST) begin
                        n_idx = r_idx + 3'd1;
                    end else begin
                        n_phase = PH_SEND;
                        n_cmd   = CMD_APP;
                        n_idx   = 3'd1;
                    end
                end
                PH_TOKEN: begin
                    if (i_in.rx_byte == TOKEN_DATA) begin
                        n_phase    = PH_DATA;
                        n_data_cnt = '0;
                    end
                end
                PH_DATA: begin
                    n_wv       = 1'b1;
                    n_wa       = r_load_base + 16'(r_data_cnt);
                    n_wd       = i_in.rx_byte;
                    n_data_cnt = data_inc;
                    if (data_inc == BLK_END) begin
                        n_phase = PH_CRC;
                        n_idx   = 3'd1;
                    end
                end
                PH_CRC: begin
                    if (r_idx < CRC_LAST) begin
                        n_idx = r_idx + 3'd1;
                    end else begin
                        n_phase = PH_DONE;
                        n_send  = 1'b0;
                        n_cs    = 1'b1;
                        n_done  = 1'b1;
                    end
                end
                default: begin
                    n_send = 1'b0;
                    n_cs   = 1'b1;
                end
            endcase
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_cmd         <= CMD_GO_IDLE;
            r_idx         <= 3'd0;
            r_poll_cnt    <= 8'd0;
            r_dummy_cnt   <= 8'd0;
            r_data_cnt    <= '0;
            r_out_valid   <= 1'b0;
            r_boot_sector <= BOOT_SECTOR_RST;
            r_load_base   <= LOAD_BASE_RST;
            r_poll_limit  <= POLL_LIMIT_RST;
            r_dummy_bytes <= DUMMY_BYTES_RST;
        end else begin
            if (in_beat) begin
                r_phase     <= n_phase;
                r_cmd       <= n_cmd;
                r_idx       <= n_idx;
                r_poll_cnt  <= n_poll_cnt;
                r_dummy_cnt <= n_dummy_cnt;
                r_data_cnt  <= n_data_cnt;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_BOOT_SECTOR: r_boot_sector <= i_cfg.data;
                    CFG_LOAD_BASE:   r_load_base   <= i_cfg.data[15:0];
                    CFG_POLL_LIMIT:  r_poll_limit  <= i_cfg.data[7:0];
                    CFG_DUMMY_BYTES: r_dummy_bytes <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Result payload, loaded on each input beat
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_tx   <= n_tx;
            r_send <= n_send;
            r_cs   <= n_cs;
            r_wv   <= n_wv;
            r_wa   <= n_wa;
            r_wd   <= n_wd;
            r_done <= n_done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.tx_byte     = r_tx;
    assign o_out.send        = r_send;
    assign o_out.cs_high     = r_cs;
    assign o_out.write_valid = r_wv;
    assign o_out.write_addr  = r_wa;
    assign o_out.write_data  = r_wd;
    assign o_out.boot_done   = r_done;

endmodule

`default_nettype wire
